// ===== src/sws_pkg.sv =====
// Shared types, codes and constants for the sliding-window sender.
// Used by sws_ctrl, sws_datapath and sliding_window_sender; no dependencies.
package sws_pkg;

  localparam int WINDOW_DEPTH_DEF = 16;

  localparam logic [1:0] KIND_NEW   = 2'd0;
  localparam logic [1:0] KIND_RESEND = 2'd1;
  localparam logic [1:0] KIND_FINAL = 2'd2;
  localparam logic [1:0] KIND_DONE  = 2'd3;

  localparam logic [1:0] REG_INIT_WINDOW  = 2'd0;
  localparam logic [1:0] REG_INIT_TIMEOUT = 2'd1;
  localparam logic [1:0] REG_TOTAL_SEGS   = 2'd2;

  localparam logic [25:0] INIT_TIMEOUT_RST = 26'd1000;
  localparam logic [4:0]  INIT_WINDOW_RST  = 5'd4;

  typedef struct packed {
    logic        op;
    logic [15:0] ack_seq;
    logic [31:0] now_ms;
  } in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] seq;
    logic [4:0]  window_now;
    logic [31:0] timeout_now;
    logic        last;
  } out_t;

  typedef enum logic [3:0] {
    S_IDLE, S_START, S_M_RD, S_M_CHK, S_DIV_LD, S_DIV, S_D_RD, S_D_CHK,
    S_E_RD, S_E_CHK, S_FILL, S_CLOSE, S_FLUSH
  } state_t;

  typedef struct packed {
    logic accept;
    logic idx_clr;
    logic idx_inc;
    logic finish;
    logic take_sample;
    logic div_load;
    logic div_step;
    logic tmo_load;
    logic retire;
    logic expire;
    logic fill;
    logic close_seg;
    logic flush;
  } cmd_t;

  typedef struct packed {
    logic fin;
    logic op;
    logic ack_zero;
    logic idx_lt_cnt;
    logic match;
    logic seq_le;
    logic expired;
    logic fill_ok;
    logic close_ok;
    logic can_emit;
    logic can_flush;
    logic pend_v;
    logic div_done;
  } stat_t;

endpackage

// ===== src/sws_ctrl.sv =====
// Sequencer for the sliding-window sender: walks match, retire, expiry,
// fill and close phases. Depends on sws_pkg.
module sws_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  sws_pkg::stat_t st,
  output sws_pkg::cmd_t  cmd
);

  sws_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sws_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sws_pkg::S_IDLE:   if (in_valid) state_nxt = sws_pkg::S_START;
      sws_pkg::S_START: begin
        priority if (st.fin) state_nxt = sws_pkg::S_IDLE;
        else if (st.op && st.ack_zero) state_nxt = sws_pkg::S_FLUSH;
        else if (st.op) state_nxt = sws_pkg::S_M_RD;
        else state_nxt = sws_pkg::S_E_RD;
      end
      sws_pkg::S_M_RD:   state_nxt = st.idx_lt_cnt ? sws_pkg::S_M_CHK : sws_pkg::S_D_RD;
      sws_pkg::S_M_CHK:  state_nxt = st.match ? sws_pkg::S_DIV_LD : sws_pkg::S_M_RD;
      sws_pkg::S_DIV_LD: state_nxt = sws_pkg::S_DIV;
      sws_pkg::S_DIV:    if (st.div_done) state_nxt = sws_pkg::S_D_RD;
      sws_pkg::S_D_RD:   state_nxt = st.idx_lt_cnt ? sws_pkg::S_D_CHK : sws_pkg::S_E_RD;
      sws_pkg::S_D_CHK:  state_nxt = st.seq_le ? sws_pkg::S_D_RD : sws_pkg::S_E_RD;
      sws_pkg::S_E_RD:   state_nxt = st.idx_lt_cnt ? sws_pkg::S_E_CHK : sws_pkg::S_FILL;
      sws_pkg::S_E_CHK:  if (!st.expired || st.can_emit) state_nxt = sws_pkg::S_E_RD;
      sws_pkg::S_FILL:   if (!st.fill_ok) state_nxt = sws_pkg::S_CLOSE;
      sws_pkg::S_CLOSE:  if (!st.close_ok || st.can_emit) state_nxt = sws_pkg::S_FLUSH;
      sws_pkg::S_FLUSH:  if (!st.pend_v || st.can_flush) state_nxt = sws_pkg::S_IDLE;
      default:           state_nxt = sws_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    unique case (state_r)
      sws_pkg::S_IDLE: begin
        in_ready = 1'b1;
        cmd.accept = in_valid;
        cmd.idx_clr = in_valid;
      end
      sws_pkg::S_START: cmd.finish = !st.fin && st.op && st.ack_zero;
      sws_pkg::S_M_RD: cmd.idx_clr = !st.idx_lt_cnt;
      sws_pkg::S_M_CHK: begin
        cmd.take_sample = st.match;
        cmd.idx_inc = !st.match;
      end
      sws_pkg::S_DIV_LD: cmd.div_load = 1'b1;
      sws_pkg::S_DIV: begin
        cmd.div_step = !st.div_done;
        cmd.tmo_load = st.div_done;
        cmd.idx_clr = st.div_done;
      end
      sws_pkg::S_D_RD: begin
        cmd.retire = !st.idx_lt_cnt;
        cmd.idx_clr = !st.idx_lt_cnt;
      end
      sws_pkg::S_D_CHK: begin
        cmd.idx_inc = st.seq_le;
        cmd.retire = !st.seq_le;
        cmd.idx_clr = !st.seq_le;
      end
      sws_pkg::S_E_RD: ;
      sws_pkg::S_E_CHK: begin
        cmd.expire = st.expired && st.can_emit;
        cmd.idx_inc = !st.expired || st.can_emit;
      end
      sws_pkg::S_FILL:  cmd.fill = st.fill_ok && st.can_emit;
      sws_pkg::S_CLOSE: cmd.close_seg = st.close_ok && st.can_emit;
      sws_pkg::S_FLUSH: cmd.flush = st.pend_v && st.can_flush;
      default: ;
    endcase
  end

endmodule

// ===== src/sws_datapath.sv =====
// Datapath of the sliding-window sender: config registers, window store,
// timeout divider and output staging. Depends on sws_pkg.
module sws_datapath #(
  parameter int WINDOW_DEPTH = sws_pkg::WINDOW_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [3:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  input  sws_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output sws_pkg::out_t  out_data,
  input  sws_pkg::cmd_t  cmd,
  output sws_pkg::stat_t st
);

  localparam int AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int WW = $clog2(WINDOW_DEPTH + 1);
  localparam logic [WW:0]   DEPTH_X = (WW + 1)'(WINDOW_DEPTH);
  localparam logic [WW-1:0] DEPTH_C = WW'(WINDOW_DEPTH);

  logic [4:0]  iw_r;
  logic [25:0] it_r;
  logic [15:0] tot_r;

  logic [AW-1:0] head_r;
  logic [WW-1:0] count_r, idx_r, limit_r, limit_nxt;
  logic [31:0]   tmo_r, h0_r, h1_r, h2_r;
  logic [16:0]   nseq_r;
  logic          active_r, fin_r;
  logic          op_r;
  logic [15:0]   ack_r;
  logic [31:0]   now_r;

  logic [34:0] dv_r;
  logic [31:0] z_r;
  logic [3:0]  k_r;
  logic [63:0] p_r;
  logic [5:0]  dcnt_r;

  logic [15:0] seq_mem [WINDOW_DEPTH];
  logic [31:0] time_mem [WINDOW_DEPTH];
  logic [15:0] rd_seq_r;
  logic [31:0] rd_time_r;

  logic          pend_v_r, out_v_r;
  sws_pkg::out_t pend_r, out_r;

  function automatic logic [AW-1:0] wrap(input logic [AW-1:0] base, input logic [WW-1:0] off);
    logic [WW:0] s;
    s = {{(WW + 1 - AW){1'b0}}, base} + {1'b0, off};
    if (s >= DEPTH_X) s = s - DEPTH_X;
    return s[AW-1:0];
  endfunction

  function automatic logic [WW-1:0] clamp_w(input logic [4:0] w);
    logic [WW+4:0] e;
    e = {{WW{1'b0}}, w};
    if (e == '0) return WW'(1);
    if (e > (WW + 5)'(WINDOW_DEPTH)) return DEPTH_C;
    return e[WW-1:0];
  endfunction

  // divide by 3 through reciprocal 171/512, exact for limits up to 256
  function automatic logic [WW-1:0] div3(input logic [WW-1:0] w);
    logic [WW+8:0] p;
    p = (WW + 9)'(w) * (WW + 9)'(171);
    return p[WW+8:9];
  endfunction

  function automatic logic [4:0] win5(input logic [WW-1:0] w);
    logic [WW+4:0] e;
    e = {5'b0, w};
    return e[4:0];
  endfunction

  // config port
  logic       wr_cfg;
  logic [1:0] cidx;
  logic [25:0] it_w;
  assign wr_cfg = psel && penable && pwrite;
  assign cidx = paddr[3:2];
  assign it_w = (pwdata[25:0] == '0) ? 26'd1 : pwdata[25:0];

  always_comb begin
    unique case (cidx)
      sws_pkg::REG_INIT_WINDOW:  prdata = {27'b0, iw_r};
      sws_pkg::REG_INIT_TIMEOUT: prdata = {6'b0, it_r};
      sws_pkg::REG_TOTAL_SEGS:   prdata = {16'b0, tot_r};
      default:                   prdata = '0;
    endcase
  end

  // window store
  logic [AW-1:0] rd_addr, wr_addr;
  logic          wr_time_en, wr_seq_en;
  logic [15:0]   wr_seq;
  assign rd_addr = wrap(head_r, idx_r);

  always_comb begin
    wr_time_en = cmd.expire || cmd.fill || cmd.close_seg;
    wr_seq_en  = cmd.fill || cmd.close_seg;
    wr_seq     = cmd.fill ? nseq_r[15:0] : 16'd0;
    priority if (cmd.fill) wr_addr = wrap(head_r, count_r);
    else if (cmd.close_seg) wr_addr = head_r;
    else wr_addr = rd_addr;
  end

  always_ff @(posedge clk) begin
    if (wr_time_en) time_mem[wr_addr] <= now_r;
    if (wr_seq_en) seq_mem[wr_addr] <= wr_seq;
    rd_seq_r  <= seq_mem[rd_addr];
    rd_time_r <= time_mem[rd_addr];
  end

  // timeout arithmetic: 13*sum/16 first, then divide by 5 using
  // 2^32 - 1 = 5 * 858993459 to fold the top bits, and a 32-bit reciprocal
  logic [31:0] age;
  logic [34:0] sum;
  logic [38:0] prod;
  logic [32:0] y5;
  logic [31:0] z5;
  logic [3:0]  k5;
  logic [34:0] q5;
  assign age  = now_r - rd_time_r;
  assign sum  = {2'b0, h0_r, 1'b0} + ({3'b0, h1_r} << 2) + {3'b0, h1_r} + {3'b0, h2_r};
  assign prod = ({4'b0, sum} << 3) + ({4'b0, sum} << 2) + {4'b0, sum};
  assign y5   = {1'b0, dv_r[31:0]} + {30'b0, dv_r[34:32]};
  assign z5   = y5[31:0] + {31'b0, y5[32]};
  assign k5   = {1'b0, dv_r[34:32]} + {3'b0, y5[32]};
  assign q5   = {31'b0, k_r} * 35'd858993459 + {5'b0, p_r[63:34]};

  always_comb begin
    limit_nxt = limit_r;
    if (cmd.retire && limit_r < DEPTH_C) limit_nxt = limit_r + WW'(1);
    if (cmd.expire) begin
      limit_nxt = div3(limit_r);
      if (limit_nxt == '0) limit_nxt = WW'(1);
    end
  end

  // output staging: one pending beat, released when the next one appears or on a flush
  sws_pkg::out_t newr;
  logic          emit;
  always_comb begin
    emit = cmd.finish || cmd.expire || cmd.fill || cmd.close_seg;
    newr.window_now  = win5(limit_nxt);
    newr.timeout_now = tmo_r;
    newr.last        = 1'b0;
    priority if (cmd.finish) begin
      newr.kind = sws_pkg::KIND_DONE;   newr.seq = '0;
    end else if (cmd.expire) begin
      newr.kind = sws_pkg::KIND_RESEND; newr.seq = rd_seq_r;
    end else if (cmd.fill) begin
      newr.kind = sws_pkg::KIND_NEW;    newr.seq = nseq_r[15:0];
    end else begin
      newr.kind = sws_pkg::KIND_FINAL;  newr.seq = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iw_r <= sws_pkg::INIT_WINDOW_RST;
      it_r <= sws_pkg::INIT_TIMEOUT_RST;
      tot_r <= '0;
      limit_r <= clamp_w(sws_pkg::INIT_WINDOW_RST);
      tmo_r <= {6'b0, sws_pkg::INIT_TIMEOUT_RST};
      h0_r <= {6'b0, sws_pkg::INIT_TIMEOUT_RST};
      h1_r <= {6'b0, sws_pkg::INIT_TIMEOUT_RST};
      h2_r <= {6'b0, sws_pkg::INIT_TIMEOUT_RST};
      head_r <= '0;
      count_r <= '0;
      idx_r <= '0;
      nseq_r <= 17'd1;
      active_r <= 1'b1;
      fin_r <= 1'b0;
      dcnt_r <= '0;
      pend_v_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (wr_cfg) begin
        unique case (cidx)
          sws_pkg::REG_INIT_WINDOW: begin
            iw_r <= pwdata[4:0];
            limit_r <= clamp_w(pwdata[4:0]);
          end
          sws_pkg::REG_INIT_TIMEOUT: begin
            it_r <= pwdata[25:0];
            tmo_r <= {6'b0, it_w};
            h0_r <= {6'b0, it_w};
            h1_r <= {6'b0, it_w};
            h2_r <= {6'b0, it_w};
          end
          sws_pkg::REG_TOTAL_SEGS: tot_r <= pwdata[15:0];
          default: ;
        endcase
      end else begin
        limit_r <= limit_nxt;
      end

      if (cmd.idx_clr) idx_r <= '0;
      else if (cmd.idx_inc) idx_r <= idx_r + WW'(1);

      if (cmd.finish) fin_r <= 1'b1;

      if (cmd.take_sample) begin
        h0_r <= age;
        h1_r <= h0_r;
        h2_r <= h1_r;
      end
      if (cmd.div_load) begin
        dv_r <= prod[38:4];
        dcnt_r <= 6'd2;
      end else if (cmd.div_step) begin
        dcnt_r <= dcnt_r - 6'd1;
        if (dcnt_r == 6'd2) begin
          z_r <= z5;
          k_r <= k5;
        end else begin
          p_r <= 64'(z_r) * 64'(32'hCCCC_CCCD);
        end
      end
      if (cmd.tmo_load) begin
        priority if (q5 == '0) tmo_r <= 32'd1;
        else if (q5[34:32] != '0) tmo_r <= '1;
        else tmo_r <= q5[31:0];
      end

      if (cmd.retire) begin
        head_r <= rd_addr;
        count_r <= count_r - idx_r;
      end
      if (cmd.fill) begin
        count_r <= count_r + WW'(1);
        nseq_r <= nseq_r + 17'd1;
      end
      if (cmd.close_seg) begin
        count_r <= WW'(1);
        active_r <= 1'b0;
      end

      // output beats
      if (cmd.flush || (emit && pend_v_r)) out_v_r <= 1'b1;
      else if (out_v_r && out_ready) out_v_r <= 1'b0;
      if (emit) pend_v_r <= 1'b1;
      else if (cmd.flush) pend_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r <= in_data.op;
      ack_r <= in_data.ack_seq;
      now_r <= in_data.now_ms;
    end
    if (emit) pend_r <= newr;
    if (emit && pend_v_r) out_r <= pend_r;
    if (cmd.flush) out_r <= {pend_r[$bits(sws_pkg::out_t)-1:1], 1'b1};
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

  assign st.fin        = fin_r;
  assign st.op         = op_r;
  assign st.ack_zero   = (ack_r == '0);
  assign st.idx_lt_cnt = (idx_r < count_r);
  assign st.match      = (rd_seq_r == ack_r);
  assign st.seq_le     = (rd_seq_r <= ack_r);
  assign st.expired    = (age > tmo_r);
  assign st.fill_ok    = (count_r < limit_r) && (count_r < DEPTH_C) && (nseq_r <= {1'b0, tot_r});
  assign st.close_ok   = active_r && (nseq_r > {1'b0, tot_r}) && (count_r == '0);
  assign st.can_emit   = !pend_v_r || !out_v_r || out_ready;
  assign st.can_flush  = !out_v_r || out_ready;
  assign st.pend_v     = pend_v_r;
  assign st.div_done   = (dcnt_r == '0);

endmodule

// ===== src/sliding_window_sender.sv =====
// Top level of the sliding-window sender: controller plus datapath.
// Depends on sws_pkg, sws_ctrl and sws_datapath.
//
// Usage: each input beat on in_* is a time tick (op 0) or an ack (op 1)
// stamped with now_ms. The block answers with zero or more result beats
// on out_* (new send, resend, final segment 0, transfer done); the last
// beat of a step carries last = 1. in_ready is high only while idle, so
// one step is processed at a time.
// Steps: accept and decode; then the match, retire and expiry scans, each
// visiting entries through a read state and a check state (single
// registered read port on the window store) until a read ends it; a
// matching ack adds the timeout update (scale by 13/16, then divide by 5
// via a folded reciprocal multiply); the fill phase then issues new sends,
// followed by the close check and a flush of the last beat.
// Results pass through a pending register and an output register; when
// the receiver stalls, the sequencer holds in place until a slot frees.
// Reset (rst_n low, synchronous) empties the window, reloads window limit
// and timeout from the reset register values, and clears finished.
module sliding_window_sender #(
  parameter int WINDOW_DEPTH = sws_pkg::WINDOW_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [3:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  input  logic          in_valid,
  output logic          in_ready,
  input  sws_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output sws_pkg::out_t out_data
);

  sws_pkg::cmd_t  cmd;
  sws_pkg::stat_t st;

  // writes never wait; user must write config over this port while idle, not enforced
  assign pready = 1'b1;

  sws_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  sws_datapath #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cmd       (cmd),
    .st        (st)
  );

endmodule

// ===== tb/sv/tb_sliding_window_sender.sv =====
// Self-checking testbench for sliding_window_sender: window fill, acks, expiry and close.
// Depends on sws_pkg and the sliding_window_sender RTL; drives the APB-style
// config port and both valid/ready channels.
module tb_sliding_window_sender;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 16;
  localparam int SETTLE_CYCLES = 300;     // worst step plus divider, with margin
  localparam int WATCHDOG_LIMIT = 20000;  // cycles with no beat on either side
  localparam int MAX_REPORTS = 10;
  localparam int OWED_DEPTH = 4096;
  localparam logic [1:0] REG_UNUSED = 2'd3;  // address past the register list

  logic        clk;
  logic        rst_n;
  logic        psel, penable, pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        pready;
  logic        in_valid, in_ready;
  sws_pkg::in_t  in_data;
  logic        out_valid, out_ready;
  sws_pkg::out_t out_data;

  sliding_window_sender #(.WINDOW_DEPTH(DEPTH)) DUT (
    .clk(clk), .rst_n(rst_n),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  // Sender model state: outstanding window, limit, timeout and samples.
  logic [15:0] win_seq [DEPTH];
  logic [31:0] win_sent [DEPTH];
  int unsigned win_cnt;
  int unsigned win_lim;
  logic [31:0] rto;
  logic [31:0] rtt [3];
  logic [16:0] next_seg;
  bit          close_pending;
  bit          xfer_done;
  logic [15:0] total_segs;

  // Ring of segment sends still owed by the block.
  sws_pkg::out_t owed_q [OWED_DEPTH];
  logic [11:0]   owed_wr, owed_rd;

  logic [31:0] t_ms;
  int          errors;
  int          n_items, n_results;
  int          kind_seen [4];
  int          idle_cycles;
  int          hold_req;
  int          hold_cnt, rx_gap;
  bit          rx_random, tx_random;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int unsigned clamp_lim(int unsigned w);
    if (w < 1) return 1;
    if (w > DEPTH) return DEPTH;
    return w;
  endfunction

  function automatic void load_rto(logic [25:0] t);
    logic [31:0] v;
    v = (t == 26'd0) ? 32'd1 : {6'd0, t};
    rto = v;
    rtt[0] = v;
    rtt[1] = v;
    rtt[2] = v;
  endfunction

  // Weighted smoothing of the last three round trips, saturating.
  function automatic void add_sample(logic [31:0] s);
    logic [63:0] sum, t;
    rtt[2] = rtt[1];
    rtt[1] = rtt[0];
    rtt[0] = s;
    sum = 64'd2 * rtt[0] + 64'd5 * rtt[1] + {32'd0, rtt[2]};
    t = (64'd13 * sum) / 64'd80;
    if (t == 64'd0) t = 64'd1;
    if (t > 64'hFFFF_FFFF) t = 64'hFFFF_FFFF;
    rto = t[31:0];
  endfunction

  function automatic void queue_send(logic [1:0] k, logic [15:0] s);
    sws_pkg::out_t r;
    r.kind = k;
    r.seq = s;
    r.window_now = win_lim[4:0];
    r.timeout_now = rto;
    r.last = 1'b0;
    owed_q[owed_wr] = r;
    owed_wr++;
  endfunction

  function automatic void mark_last();
    owed_q[owed_wr - 12'd1].last = 1'b1;
  endfunction

  function automatic void sender_reset();
    win_cnt = 0;
    win_lim = clamp_lim(sws_pkg::INIT_WINDOW_RST);
    load_rto(sws_pkg::INIT_TIMEOUT_RST);
    next_seg = 17'd1;
    close_pending = 1'b1;
    xfer_done = 1'b0;
    total_segs = 16'd0;
  endfunction

  function automatic void sender_config(logic [1:0] idx, logic [31:0] v);
    case (idx)
      sws_pkg::REG_INIT_WINDOW: win_lim = clamp_lim(v[4:0]);
      sws_pkg::REG_INIT_TIMEOUT: load_rto(v[25:0]);
      sws_pkg::REG_TOTAL_SEGS: total_segs = v[15:0];
      default: ;
    endcase
  endfunction

  // Work out every segment send that one tick or ack causes.
  function automatic void sender_step(sws_pkg::in_t b);
    int unsigned i, drop;
    logic [11:0] n0;
    bit hit;
    n0 = owed_wr;
    if (xfer_done) return;
    if (b.op) begin
      if (b.ack_seq == 16'd0) begin
        xfer_done = 1'b1;
        queue_send(sws_pkg::KIND_DONE, 16'd0);
        mark_last();
        return;
      end
      hit = 1'b0;
      for (i = 0; i < win_cnt; i++) begin
        if (!hit && win_seq[i] == b.ack_seq) begin
          add_sample(b.now_ms - win_sent[i]);
          hit = 1'b1;
        end
      end
      // Cumulative ack: retire the head of the window up to ack_seq.
      drop = 0;
      while (drop < win_cnt && win_seq[drop] <= b.ack_seq) drop++;
      for (i = 0; i + drop < win_cnt; i++) begin
        win_seq[i] = win_seq[i + drop];
        win_sent[i] = win_sent[i + drop];
      end
      win_cnt -= drop;
      if (win_lim < DEPTH) win_lim++;
    end
    for (i = 0; i < win_cnt; i++) begin
      if (b.now_ms - win_sent[i] > rto) begin
        win_lim = win_lim / 3;
        if (win_lim == 0) win_lim = 1;
        win_sent[i] = b.now_ms;
        queue_send(sws_pkg::KIND_RESEND, win_seq[i]);
      end
    end
    while (win_cnt < win_lim && win_cnt < DEPTH && next_seg <= {1'b0, total_segs}) begin
      win_seq[win_cnt] = next_seg[15:0];
      win_sent[win_cnt] = b.now_ms;
      win_cnt++;
      queue_send(sws_pkg::KIND_NEW, next_seg[15:0]);
      next_seg++;
    end
    if (close_pending && next_seg > {1'b0, total_segs} && win_cnt == 0) begin
      win_seq[0] = 16'd0;
      win_sent[0] = b.now_ms;
      win_cnt = 1;
      queue_send(sws_pkg::KIND_FINAL, 16'd0);
      close_pending = 1'b0;
    end
    if (owed_wr != n0) mark_last();
  endfunction

  function automatic void note_error(string msg);
    errors++;
    if (errors <= MAX_REPORTS) $display("ERROR @%0t: %s", $realtime, msg);
  endfunction

  // Compare each result beat with the oldest owed send. Sample at the falling
  // edge: the beat completes at the next rising edge with these values.
  always @(negedge clk) begin
    sws_pkg::out_t e;
    if (rst_n && out_valid && out_ready) begin
      n_results++;
      kind_seen[out_data.kind]++;
      if (owed_wr == owed_rd) begin
        note_error($sformatf("result beat with nothing owed: kind %0d seq %0d",
                             out_data.kind, out_data.seq));
      end else begin
        e = owed_q[owed_rd];
        owed_rd++;
        if (out_data.kind !== e.kind || out_data.seq !== e.seq ||
            out_data.window_now !== e.window_now ||
            out_data.timeout_now !== e.timeout_now || out_data.last !== e.last)
          note_error($sformatf({"exp kind %0d seq %0d win %0d tmo %0d last %0d, ",
                                "got kind %0d seq %0d win %0d tmo %0d last %0d"},
                               e.kind, e.seq, e.window_now, e.timeout_now, e.last,
                               out_data.kind, out_data.seq, out_data.window_now,
                               out_data.timeout_now, out_data.last));
      end
    end
  end

  // Watchdog: end the run when neither channel moves for too long.
  always @(negedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("sliding_window_sender test failed");
        $finish;
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Receiver: a requested hold-off wins, else random stalls when enabled.
  always @(posedge clk) begin
    if (hold_req > 0) begin
      hold_cnt = hold_req;
      hold_req = 0;
    end
    if (hold_cnt > 0) begin
      out_ready <= 1'b0;
      hold_cnt--;
    end else if (rx_gap > 0) begin
      out_ready <= 1'b0;
      rx_gap--;
    end else begin
      out_ready <= 1'b1;
      if (rx_random && $urandom_range(0, 4) == 0) rx_gap = pick_gap();
    end
  end

  // Two-phase APB write; the register takes the value on the access edge.
  task automatic cfg_write(logic [1:0] idx, logic [31:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    sender_config(idx, v);
  endtask

  // Offer one beat, hold it until taken, then maybe drop valid for a gap.
  task automatic send_beat(logic op, logic [15:0] ack);
    sws_pkg::in_t b;
    int gap, r;
    b.op = op;
    b.ack_seq = ack;
    b.now_ms = t_ms;
    in_valid <= 1'b1;
    in_data <= b;
    do @(negedge clk); while (!in_ready);
    sender_step(b);
    n_items++;
    @(posedge clk);
    gap = 0;
    if (tx_random) begin
      r = $urandom_range(0, 99);
      if (r >= 90) gap = $urandom_range(10, 50);
      else if (r >= 55) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop valid, wait for every owed send, then let a silent step finish.
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (owed_wr != owed_rd);
    @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Advance the clock in ms: mostly inside the timeout, some past it.
  task automatic advance_time();
    int r;
    logic [31:0] span;
    span = (rto > 32'd100000) ? 32'd100000 : rto;
    r = $urandom_range(0, 99);
    if (r < 70) t_ms += $urandom_range(0, span);
    else if (r < 95) t_ms += rto + $urandom_range(1, span + 1);
    else t_ms = $urandom();
  endtask

  // Mostly ack a segment in flight; otherwise an arbitrary nonzero number.
  function automatic logic [15:0] pick_ack();
    logic [15:0] a;
    if (win_cnt > 0 && $urandom_range(0, 99) < 75)
      a = win_seq[$urandom_range(0, win_cnt - 1)];
    else
      a = 16'($urandom_range(1, 65535));
    return (a == 16'd0) ? 16'd1 : a;
  endfunction

  task automatic random_beats(int count);
    for (int i = 0; i < count; i++) begin
      advance_time();
      if ($urandom_range(0, 99) < 60) send_beat(1'b1, pick_ack());
      else send_beat(1'b0, 16'd0);
    end
  endtask

  // Fill at reset defaults, matched ack, unmatched ack past the window.
  task automatic test_basic_flow();
    cfg_write(sws_pkg::REG_TOTAL_SEGS, 32'd20);
    t_ms = 32'd0;
    send_beat(1'b0, 16'd0);
    t_ms += 32'd40;
    send_beat(1'b1, 16'd2);
    t_ms += 32'd10;
    send_beat(1'b1, 16'd999);
    send_beat(1'b1, 16'd3);
    drain();
  endtask

  // Window register extremes: zero clamps to one, all ones clamps to the depth.
  task automatic test_window_clamp();
    cfg_write(sws_pkg::REG_INIT_WINDOW, 32'd0);
    cfg_write(REG_UNUSED, 32'hFFFF_FFFF);
    t_ms += 32'd5;
    send_beat(1'b1, 16'hFFFF);
    drain();
    cfg_write(sws_pkg::REG_INIT_WINDOW, 32'hFFFF_FFFF);
    cfg_write(sws_pkg::REG_TOTAL_SEGS, {16'hFFFF, next_seg[15:0] + 16'd40});
    send_beat(1'b0, 16'd0);
    for (int i = 0; i < 3; i++) begin
      t_ms += 32'd3;
      send_beat(1'b1, win_seq[0]);
    end
    drain();
  endtask

  // Minimum timeout: every entry expires and the limit falls to its floor.
  task automatic test_expiry_floor();
    cfg_write(sws_pkg::REG_INIT_TIMEOUT, 32'd0);
    cfg_write(sws_pkg::REG_INIT_WINDOW, 32'd16);
    send_beat(1'b0, 16'd0);
    t_ms += 32'd5;
    send_beat(1'b0, 16'd0);
    t_ms += 32'd1;
    send_beat(1'b0, 16'd0);
    t_ms += 32'd2;
    send_beat(1'b1, 16'hFFFF);
    drain();
  endtask

  // A large initial timeout, time wrapping past all ones, and a saturating timeout.
  task automatic test_timeout_extremes();
    cfg_write(sws_pkg::REG_INIT_TIMEOUT, 32'd65535000);
    cfg_write(sws_pkg::REG_TOTAL_SEGS, {16'd0, next_seg[15:0] + 16'd60});
    t_ms = 32'hFFFF_FFF0;
    send_beat(1'b0, 16'd0);
    t_ms = 32'hFFFF_FFFF;
    send_beat(1'b0, 16'd0);
    t_ms += 32'h20;
    send_beat(1'b1, win_seq[0]);
    t_ms += 32'hF000_0000;
    send_beat(1'b1, win_seq[0]);
    t_ms += 32'hF000_0000;
    send_beat(1'b1, win_seq[0]);
    t_ms += 32'hF000_0000;
    send_beat(1'b1, win_seq[0]);
    drain();
  endtask

  // Random phases over several register settings, with and without idling.
  task automatic test_random_phases();
    cfg_write(sws_pkg::REG_INIT_WINDOW, 32'd4);
    cfg_write(sws_pkg::REG_INIT_TIMEOUT, 32'd50);
    cfg_write(sws_pkg::REG_TOTAL_SEGS, {16'd0, next_seg[15:0] + 16'd200});
    rx_random = 1'b1;
    tx_random = 1'b1;
    random_beats(100);
    drain();
    cfg_write(sws_pkg::REG_INIT_WINDOW, 32'd16);
    cfg_write(sws_pkg::REG_INIT_TIMEOUT, 32'd1);
    cfg_write(sws_pkg::REG_TOTAL_SEGS, {16'd0, next_seg[15:0] + 16'd150});
    rx_random = 1'b0;
    tx_random = 1'b0;
    random_beats(80);
    drain();
    cfg_write(sws_pkg::REG_INIT_WINDOW, 32'd1);
    cfg_write(sws_pkg::REG_INIT_TIMEOUT, 32'h03FF_FFFF);
    cfg_write(sws_pkg::REG_TOTAL_SEGS, 32'd65535);
    rx_random = 1'b1;
    tx_random = 1'b1;
    random_beats(60);
    drain();
    cfg_write(sws_pkg::REG_INIT_WINDOW, $urandom_range(1, 16));
    cfg_write(sws_pkg::REG_INIT_TIMEOUT, $urandom_range(1, 5000));
    random_beats(60);
    // Pause the sender until every owed send is out, then carry on.
    drain();
    random_beats(75);
    drain();
  endtask

  // Long receiver hold-off while the sender keeps offering beats.
  task automatic test_backpressure();
    cfg_write(sws_pkg::REG_INIT_WINDOW, 32'd16);
    cfg_write(sws_pkg::REG_INIT_TIMEOUT, 32'd20);
    tx_random = 1'b0;
    hold_req = 400;
    random_beats(60);
    tx_random = 1'b1;
    drain();
  endtask

  // Close out: all data acked gives segment 0, then the final ack ends it all.
  task automatic test_close_and_finish();
    cfg_write(sws_pkg::REG_TOTAL_SEGS, {15'd0, next_seg - 17'd1});
    t_ms += 32'd1;
    send_beat(1'b1, 16'hFFFF);
    t_ms += 32'd1;
    send_beat(1'b0, 16'd0);
    send_beat(1'b1, 16'd0);
    send_beat(1'b0, 16'd0);
    send_beat(1'b1, 16'd7);
    t_ms += 32'h8000_0000;
    send_beat(1'b0, 16'd0);
    drain();
  endtask

  initial begin
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    owed_wr = '0;
    owed_rd = '0;
    errors = 0;
    n_items = 0;
    n_results = 0;
    kind_seen = '{default: 0};
    idle_cycles = 0;
    hold_req = 0;
    hold_cnt = 0;
    rx_gap = 0;
    rx_random = 1'b1;
    tx_random = 1'b1;
    t_ms = 32'd0;
    sender_reset();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_basic_flow();
    test_window_clamp();
    test_expiry_floor();
    test_timeout_extremes();
    test_random_phases();
    test_backpressure();
    test_close_and_finish();

    $display("Run covered %0d input beats and %0d result beats", n_items, n_results);
    $display("  new %0d, resend %0d, final %0d, done %0d; %0d mismatches",
             kind_seen[sws_pkg::KIND_NEW], kind_seen[sws_pkg::KIND_RESEND],
             kind_seen[sws_pkg::KIND_FINAL], kind_seen[sws_pkg::KIND_DONE], errors);
    if (errors == 0 && owed_wr == owed_rd) begin
      $display("sliding_window_sender test passed");
    end else begin
      $display("sliding_window_sender test failed");
    end
    $finish;
  end

endmodule
